// File: rtl/core/assert_macros.svh
// Assertion macros shared by the PPM frame decoder RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppm decoder assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppm decoder assertion failed");

`endif

// File: rtl/core/ppmfd_pkg.sv
// Shared types and constants for the PPM frame decoder.
// Used by ppmfd_ctrl, ppmfd_dpath and ppm_frame_decoder; no dependencies.
package ppmfd_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GAP_MIN   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GAP_MAX   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP    = 3'd6;

  // Register reset values.
  localparam logic [15:0] SYNC_MIN_RST  = 16'd5000;
  localparam logic [15:0] SYNC_MAX_RST  = 16'd40000;
  localparam logic [15:0] PULSE_MIN_RST = 16'd550;
  localparam logic [15:0] PULSE_MAX_RST = 16'd1300;
  localparam logic [15:0] GAP_MIN_RST   = 16'd550;
  localparam logic [15:0] GAP_MAX_RST   = 16'd3450;
  localparam logic [7:0]  WARMUP_RST    = 8'd8;

  // Event codes reported with each result.
  typedef enum logic [3:0] {
    EV_IGNORED  = 4'd0,
    EV_LOST     = 4'd1,
    EV_FOUND    = 4'd2,
    EV_REJECT   = 4'd3,
    EV_LEARNED  = 4'd4,
    EV_WARMUP   = 4'd5,
    EV_FAILSAFE = 4'd6,
    EV_ACCEPT   = 4'd7,
    EV_STORED   = 4'd8
  } event_e;

  // Interval classification against the windows and the decoder state.
  typedef enum logic [3:0] {
    CLS_IGNORE,
    CLS_LOST,
    CLS_FOUND,
    CLS_REJECT,
    CLS_LEARN,
    CLS_ACCEPT,
    CLS_FAILSAFE,
    CLS_WARMUP,
    CLS_STORE
  } cls_e;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_APPLY,
    CMD_STORE,
    CMD_COPY,
    CMD_EMIT,
    CMD_LOAD
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STORE,
    ST_COPY,
    ST_EMIT,
    ST_RESULT
  } state_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    cls_e cls;
    logic copy_last;
    logic emit_last;
    logic can_load;
  } status_t;

  // Input beat.
  typedef struct packed {
    logic [15:0] stamp;
    logic        edge_level;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [3:0]  event_res;
    logic        synced;
    logic [3:0]  detected_channels;
    logic [2:0]  channel_index;
    logic [15:0] channel_width;
    logic        value_valid;
    logic        last;
  } out_t;

endpackage

// File: rtl/core/ppmfd_ctrl.sv
// Sequencing state machine for the PPM frame decoder.
// Depends on ppmfd_pkg; drives commands into ppmfd_dpath.
module ppmfd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ppmfd_pkg::status_t status_i,
  output ppmfd_pkg::cmd_e    cmd_o
);

  ppmfd_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppmfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = ppmfd_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ppmfd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = ppmfd_pkg::CMD_CAPTURE;
          state_d = ppmfd_pkg::ST_DECIDE;
        end
      end
      ppmfd_pkg::ST_DECIDE: begin
        cmd_o = ppmfd_pkg::CMD_APPLY;
        unique case (status_i.cls)
          ppmfd_pkg::CLS_STORE:    state_d = ppmfd_pkg::ST_STORE;
          ppmfd_pkg::CLS_FAILSAFE: state_d = ppmfd_pkg::ST_COPY;
          ppmfd_pkg::CLS_ACCEPT:   state_d = ppmfd_pkg::ST_EMIT;
          default:                 state_d = ppmfd_pkg::ST_RESULT;
        endcase
      end
      ppmfd_pkg::ST_STORE: begin
        cmd_o   = ppmfd_pkg::CMD_STORE;
        state_d = ppmfd_pkg::ST_RESULT;
      end
      ppmfd_pkg::ST_COPY: begin
        cmd_o = ppmfd_pkg::CMD_COPY;
        if (status_i.copy_last) begin
          state_d = ppmfd_pkg::ST_RESULT;
        end
      end
      ppmfd_pkg::ST_EMIT: begin
        if (status_i.can_load) begin
          cmd_o = ppmfd_pkg::CMD_EMIT;
          if (status_i.emit_last) begin
            state_d = ppmfd_pkg::ST_IDLE;
          end
        end
      end
      ppmfd_pkg::ST_RESULT: begin
        if (status_i.can_load) begin
          cmd_o   = ppmfd_pkg::CMD_LOAD;
          state_d = ppmfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppmfd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/ppmfd_dpath.sv
// Datapath of the PPM frame decoder: registers, interval windows, width banks
// and the output register. Depends on ppmfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppmfd_dpath #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ppmfd_pkg::CfgDataW-1:0]      cfg_data_i,
  input  ppmfd_pkg::in_t                      in_data_i,
  input  ppmfd_pkg::cmd_e                     cmd_i,
  output ppmfd_pkg::status_t                  status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ppmfd_pkg::out_t                     out_data_o
);

  localparam int unsigned ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHANNELS);

  // Configuration registers.
  logic [15:0] sync_min_q, sync_max_q, pulse_min_q, pulse_max_q;
  logic [15:0] gap_min_q, gap_max_q;

  // Decoder state.
  logic [15:0]     prev_q, w_q;
  logic            level_q;
  logic            mode_q, synced_q, polarity_q, active_q, failsafe_q;
  logic [CntW-1:0] run_q, learned_q;
  logic [7:0]      warmup_left_q;
  logic [ChW-1:0]  k_q;

  // Pending single result.
  ppmfd_pkg::event_e ev_q;
  logic [ChW-1:0]    res_idx_q;
  logic [15:0]       res_width_q;
  logic              res_valid_q;

  // Output register.
  ppmfd_pkg::out_t out_q;
  logic            out_valid_q;

  // Width banks, two of MAX_CHANNELS entries.
  logic [15:0] bank_q [2][MAX_CHANNELS];

  ppmfd_pkg::cls_e cls;
  logic [ChW-1:0]  run_idx;
  logic [15:0]     src_width;
  logic [16:0]     sum;
  logic [15:0]     avg;
  logic            copy_last, emit_last, can_load;

  assign run_idx   = run_q[ChW-1:0];
  assign can_load  = !out_valid_q || out_ready_i;
  assign copy_last = (CntW'(k_q) + CntW'(1)) == run_q;
  assign emit_last = (CntW'(k_q) + CntW'(1)) == learned_q;

  // Gap averaging against the active bank.
  assign src_width = bank_q[active_q][run_idx];
  assign sum       = {1'b0, w_q} + {1'b0, src_width};
  assign avg       = sum[16:1];

  // Interval classification in window order.
  always_comb begin
    cls = ppmfd_pkg::CLS_IGNORE;
    priority if (w_q > sync_max_q) begin
      cls = ppmfd_pkg::CLS_LOST;
    end else if (w_q > sync_min_q) begin
      priority if (!mode_q) begin
        cls = ppmfd_pkg::CLS_FOUND;
      end else if ((polarity_q != level_q) || (run_q == '0)) begin
        cls = ppmfd_pkg::CLS_REJECT;
      end else if (learned_q == '0) begin
        cls = ppmfd_pkg::CLS_LEARN;
      end else if (learned_q != run_q) begin
        cls = ppmfd_pkg::CLS_REJECT;
      end else if (failsafe_q) begin
        cls = ppmfd_pkg::CLS_ACCEPT;
      end else if (warmup_left_q == '0) begin
        cls = ppmfd_pkg::CLS_FAILSAFE;
      end else begin
        cls = ppmfd_pkg::CLS_WARMUP;
      end
    end else if (!mode_q || (run_q >= MaxCnt)) begin
      cls = ppmfd_pkg::CLS_IGNORE;
    end else if ((w_q < pulse_min_q) || (w_q < pulse_max_q) || (w_q < gap_min_q)) begin
      cls = ppmfd_pkg::CLS_IGNORE;
    end else if ((w_q < gap_max_q) && (polarity_q == level_q)) begin
      cls = ppmfd_pkg::CLS_STORE;
    end else begin
      cls = ppmfd_pkg::CLS_IGNORE;
    end
  end

  assign status_o.cls       = cls;
  assign status_o.copy_last = copy_last;
  assign status_o.emit_last = emit_last;
  assign status_o.can_load  = can_load;

  // Configuration and decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_min_q      <= ppmfd_pkg::SYNC_MIN_RST;
      sync_max_q      <= ppmfd_pkg::SYNC_MAX_RST;
      pulse_min_q     <= ppmfd_pkg::PULSE_MIN_RST;
      pulse_max_q     <= ppmfd_pkg::PULSE_MAX_RST;
      gap_min_q       <= ppmfd_pkg::GAP_MIN_RST;
      gap_max_q       <= ppmfd_pkg::GAP_MAX_RST;
      warmup_left_q   <= ppmfd_pkg::WARMUP_RST;
      prev_q          <= '0;
      mode_q          <= 1'b0;
      synced_q        <= 1'b0;
      polarity_q      <= 1'b0;
      active_q        <= 1'b0;
      failsafe_q      <= 1'b0;
      run_q           <= '0;
      learned_q       <= '0;
      k_q             <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ppmfd_pkg::CFG_SYNC_MIN:  sync_min_q  <= cfg_data_i;
          ppmfd_pkg::CFG_SYNC_MAX:  sync_max_q  <= cfg_data_i;
          ppmfd_pkg::CFG_PULSE_MIN: pulse_min_q <= cfg_data_i;
          ppmfd_pkg::CFG_PULSE_MAX: pulse_max_q <= cfg_data_i;
          ppmfd_pkg::CFG_GAP_MIN:   gap_min_q   <= cfg_data_i;
          ppmfd_pkg::CFG_GAP_MAX:   gap_max_q   <= cfg_data_i;
          // The warm-up count is only ever used as the countdown start.
          ppmfd_pkg::CFG_WARMUP: begin
            warmup_left_q <= cfg_data_i[7:0];
          end
          default: ;
        endcase
      end
      unique case (cmd_i)
        ppmfd_pkg::CMD_CAPTURE: begin
          prev_q <= in_data_i.stamp;
        end
        ppmfd_pkg::CMD_APPLY: begin
          k_q <= '0;
          unique case (cls)
            ppmfd_pkg::CLS_LOST: begin
              mode_q   <= 1'b0;
              synced_q <= 1'b0;
              run_q    <= '0;
            end
            ppmfd_pkg::CLS_FOUND: begin
              mode_q     <= 1'b1;
              polarity_q <= level_q;
              run_q      <= '0;
            end
            ppmfd_pkg::CLS_REJECT: begin
              run_q <= '0;
            end
            ppmfd_pkg::CLS_LEARN: begin
              learned_q <= run_q;
              run_q     <= '0;
            end
            ppmfd_pkg::CLS_ACCEPT: begin
              active_q <= ~active_q;
              synced_q <= 1'b1;
              run_q    <= '0;
            end
            ppmfd_pkg::CLS_WARMUP: begin
              warmup_left_q <= warmup_left_q - 8'd1;
              run_q         <= '0;
            end
            default: ;
          endcase
        end
        ppmfd_pkg::CMD_STORE: begin
          run_q <= run_q + CntW'(1);
        end
        ppmfd_pkg::CMD_COPY: begin
          k_q <= k_q + ChW'(1);
          if (copy_last) begin
            active_q   <= 1'b0;
            failsafe_q <= 1'b1;
            run_q      <= '0;
          end
        end
        ppmfd_pkg::CMD_EMIT: begin
          k_q <= k_q + ChW'(1);
        end
        default: ;
      endcase
    end
  end

  // Captured interval, edge level and the pending result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i == ppmfd_pkg::CMD_CAPTURE) begin
      w_q     <= in_data_i.stamp - prev_q;
      level_q <= in_data_i.edge_level;
    end
    if (cmd_i == ppmfd_pkg::CMD_APPLY) begin
      res_idx_q   <= '0;
      res_width_q <= '0;
      res_valid_q <= 1'b0;
      unique case (cls)
        ppmfd_pkg::CLS_LOST:   ev_q <= ppmfd_pkg::EV_LOST;
        ppmfd_pkg::CLS_FOUND:  ev_q <= ppmfd_pkg::EV_FOUND;
        ppmfd_pkg::CLS_REJECT: ev_q <= ppmfd_pkg::EV_REJECT;
        ppmfd_pkg::CLS_LEARN:  ev_q <= ppmfd_pkg::EV_LEARNED;
        ppmfd_pkg::CLS_WARMUP: ev_q <= ppmfd_pkg::EV_WARMUP;
        default:               ev_q <= ppmfd_pkg::EV_IGNORED;
      endcase
    end else if (cmd_i == ppmfd_pkg::CMD_STORE) begin
      ev_q        <= ppmfd_pkg::EV_STORED;
      res_idx_q   <= run_idx;
      res_width_q <= avg;
      res_valid_q <= 1'b1;
    end else if ((cmd_i == ppmfd_pkg::CMD_COPY) && copy_last) begin
      ev_q <= ppmfd_pkg::EV_FAILSAFE;
    end
  end

  // Width banks: stores write the pending bank, the failsafe copy walks it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          bank_q[b][c] <= '0;
        end
      end
    end else if (cmd_i == ppmfd_pkg::CMD_STORE) begin
      bank_q[~active_q][run_idx] <= avg;
    end else if (cmd_i == ppmfd_pkg::CMD_COPY) begin
      bank_q[~active_q][k_q] <= bank_q[active_q][k_q];
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i == ppmfd_pkg::CMD_LOAD) || (cmd_i == ppmfd_pkg::CMD_EMIT)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i == ppmfd_pkg::CMD_LOAD) begin
      out_q.event_res         <= ev_q;
      out_q.synced            <= synced_q;
      out_q.detected_channels <= 4'(learned_q);
      out_q.channel_index     <= 3'(res_idx_q);
      out_q.channel_width     <= res_width_q;
      out_q.value_valid       <= res_valid_q;
      out_q.last              <= 1'b1;
    end else if (cmd_i == ppmfd_pkg::CMD_EMIT) begin
      out_q.event_res         <= ppmfd_pkg::EV_ACCEPT;
      out_q.synced            <= synced_q;
      out_q.detected_channels <= 4'(learned_q);
      out_q.channel_index     <= 3'(k_q);
      out_q.channel_width     <= bank_q[active_q][k_q];
      out_q.value_valid       <= 1'b1;
      out_q.last              <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The running count never passes the bank depth.
  `ASSERT_IMPLIES(a_run_bound, 1'b1, run_q <= MaxCnt)
  // A stored gap advances the running count by one.
  `ASSERT_NEXT(a_store_inc, cmd_i == ppmfd_pkg::CMD_STORE, run_q == $past(run_q) + CntW'(1))
  // The end of the failsafe copy leaves bank zero active and the copy marked.
  `ASSERT_NEXT(a_fs_done, (cmd_i == ppmfd_pkg::CMD_COPY) && copy_last,
               !active_q && failsafe_q && (run_q == '0))
  // Frames are only accepted once the failsafe copy exists.
  `ASSERT_IMPLIES(a_sync_fs, synced_q, failsafe_q)

endmodule

// File: rtl/core/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: controller plus datapath.
// Depends on ppmfd_pkg, ppmfd_ctrl and ppmfd_dpath.
//
//  Port group   Direction  Handshake          Beat
//  cfg          in         cfg_we_i           register index + 16-bit data
//  in           in         in_valid_i/ready   ppmfd_pkg::in_t (capture time, edge level)
//  out          out        out_valid_o/ready  ppmfd_pkg::out_t (one result)
//
// An edge is captured (IDLE) and classified (DECIDE), then its result is handed
// to the output register (RESULT); a stored gap adds the bank update (STORE).
// A failsafe frame walks the pending bank channel by channel before its result;
// an accepted frame emits one beat per cycle while the output is not stalled.
// The next edge is taken as soon as the last result sits in the output register.
// Reset is asynchronous and clears the width banks at once; stalls on the output
// hold the controller in place without losing results.
module ppm_frame_decoder #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppmfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ppmfd_pkg::in_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ppmfd_pkg::out_t                out_data_o
);

  ppmfd_pkg::status_t status;
  ppmfd_pkg::cmd_e    cmd;

  // Sequencer.
  ppmfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, windows, banks and output register.
  ppmfd_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ppm_frame_decoder: edge beats in, result beats out.
// Depends on ppmfd_pkg and the decoder RTL; holds its own behavioral predictor.
module tb;

  localparam int CHANS       = 8;
  localparam int CYCLE_LIMIT = 500000;

  // Receiver stall styles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SLOW
  } rx_mode_e;

  // One row of the directed script: interval to the previous edge, edge level,
  // and the expected event where it is obvious by inspection.
  typedef struct packed {
    logic [15:0]       delta;
    logic              level;
    logic              typed;
    ppmfd_pkg::event_e ev;
    logic [3:0]        chans;
  } script_row_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [ppmfd_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ppmfd_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  ppmfd_pkg::in_t                 in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  ppmfd_pkg::out_t                out_data_o;

  // Predictor copy of the registers.
  logic [15:0] sync_min_q  = ppmfd_pkg::SYNC_MIN_RST;
  logic [15:0] sync_max_q  = ppmfd_pkg::SYNC_MAX_RST;
  logic [15:0] pulse_min_q = ppmfd_pkg::PULSE_MIN_RST;
  logic [15:0] pulse_max_q = ppmfd_pkg::PULSE_MAX_RST;
  logic [15:0] gap_min_q   = ppmfd_pkg::GAP_MIN_RST;
  logic [15:0] gap_max_q   = ppmfd_pkg::GAP_MAX_RST;
  logic [7:0]  warmup_q    = ppmfd_pkg::WARMUP_RST;

  // Predictor copy of the decoder state.
  logic [15:0] prev_stamp  = '0;
  logic        capture_q   = 1'b0;
  logic        synced_q    = 1'b0;
  logic        polarity_q  = 1'b0;
  logic [3:0]  run_cnt     = '0;
  logic [3:0]  learned_q   = '0;
  logic        bank_sel    = 1'b0;
  logic        failsafe_q  = 1'b0;
  logic [7:0]  warmup_left = ppmfd_pkg::WARMUP_RST;
  logic [15:0] width_bank [2][CHANS] = '{default: '0};

  ppmfd_pkg::out_t edge_results [$];
  ppmfd_pkg::out_t expected_beats [$];
  ppmfd_pkg::out_t want_beat;
  logic [15:0]     edge_stamp = '0;
  int              burst_left = 0;
  int              sent_cnt   = 0;
  int              errors     = 0;
  int              cycle_cnt  = 0;
  rx_mode_e        rx_mode    = RX_OPEN;

  script_row_t script [25] = '{
    '{16'd100,   1'b1, 1'b1, ppmfd_pkg::EV_IGNORED, 4'd0},  // short interval while searching
    '{16'd65535, 1'b0, 1'b1, ppmfd_pkg::EV_LOST,    4'd0},  // largest interval, wraps the timer
    '{16'd40000, 1'b1, 1'b1, ppmfd_pkg::EV_FOUND,   4'd0},  // sync right at the upper bound
    '{16'd1000,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},  // marker pulse
    '{16'd1300,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},  // shortest gap
    '{16'd3449,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},  // longest gap
    '{16'd3450,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},  // gap too long
    '{16'd2000,  1'b0, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},  // gap of the wrong polarity
    '{16'd549,   1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},  // glitch
    '{16'd5001,  1'b0, 1'b1, ppmfd_pkg::EV_REJECT,  4'd0},  // sync of the wrong polarity
    '{16'd5000,  1'b1, 1'b1, ppmfd_pkg::EV_IGNORED, 4'd0},  // dead zone at the sync bound
    '{16'd5001,  1'b1, 1'b1, ppmfd_pkg::EV_REJECT,  4'd0},  // empty frame
    '{16'd1400,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd1700,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd2000,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd2300,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd2600,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd2900,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd3200,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd3400,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd1500,  1'b1, 1'b1, ppmfd_pkg::EV_IGNORED, 4'd0},  // ninth gap of a full frame
    '{16'd20000, 1'b1, 1'b1, ppmfd_pkg::EV_LEARNED, 4'd8},  // first complete frame
    '{16'd2000,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd2000,  1'b1, 1'b0, ppmfd_pkg::EV_IGNORED, 4'd0},
    '{16'd6000,  1'b1, 1'b1, ppmfd_pkg::EV_REJECT,  4'd8}   // count mismatch
  };

  ppm_frame_decoder #(
    .MAX_CHANNELS(CHANS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor register write; the warm-up write also reloads the countdown.
  task automatic apply_reg(input logic [ppmfd_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] val);
    case (idx)
      ppmfd_pkg::CFG_SYNC_MIN:  sync_min_q = val;
      ppmfd_pkg::CFG_SYNC_MAX:  sync_max_q = val;
      ppmfd_pkg::CFG_PULSE_MIN: pulse_min_q = val;
      ppmfd_pkg::CFG_PULSE_MAX: pulse_max_q = val;
      ppmfd_pkg::CFG_GAP_MIN:   gap_min_q = val;
      ppmfd_pkg::CFG_GAP_MAX:   gap_max_q = val;
      ppmfd_pkg::CFG_WARMUP: begin
        warmup_q    = val[7:0];
        warmup_left = val[7:0];
      end
      default: ;
    endcase
  endtask

  function automatic void note_result(input ppmfd_pkg::event_e ev, input logic [2:0] idx,
                                      input logic [15:0] w, input logic vld,
                                      input logic lst);
    ppmfd_pkg::out_t r;
    r.event_res         = ev;
    r.synced            = synced_q;
    r.detected_channels = learned_q;
    r.channel_index     = idx;
    r.channel_width     = w;
    r.value_valid       = vld;
    r.last              = lst;
    edge_results.push_back(r);
  endfunction

  // Predicts the result beats caused by one edge into edge_results.
  task automatic decode_edge(input ppmfd_pkg::in_t beat);
    logic [15:0]       span;
    logic [16:0]       sum;
    ppmfd_pkg::event_e ev;
    logic              emitted;
    int                k;
    edge_results.delete();
    span       = beat.stamp - prev_stamp;
    prev_stamp = beat.stamp;
    ev         = ppmfd_pkg::EV_IGNORED;
    emitted    = 1'b0;
    if (span > sync_max_q) begin
      capture_q = 1'b0;
      synced_q  = 1'b0;
      run_cnt   = '0;
      ev        = ppmfd_pkg::EV_LOST;
    end else if (span > sync_min_q) begin
      if (!capture_q) begin
        capture_q  = 1'b1;
        polarity_q = beat.edge_level;
        ev         = ppmfd_pkg::EV_FOUND;
      end else if (polarity_q != beat.edge_level || run_cnt == 0) begin
        ev = ppmfd_pkg::EV_REJECT;
      end else if (learned_q == 0) begin
        learned_q = run_cnt;
        ev        = ppmfd_pkg::EV_LEARNED;
      end else if (learned_q != run_cnt) begin
        ev = ppmfd_pkg::EV_REJECT;
      end else if (failsafe_q) begin
        // Good frame after the failsafe copy: swap banks and emit the run.
        bank_sel = ~bank_sel;
        synced_q = 1'b1;
        for (k = 0; k < int'(learned_q); k++)
          note_result(ppmfd_pkg::EV_ACCEPT, 3'(k), width_bank[bank_sel][k], 1'b1,
                      k == int'(learned_q) - 1);
        emitted = 1'b1;
      end else if (warmup_left == 0) begin
        for (k = 0; k < int'(run_cnt); k++)
          width_bank[~bank_sel][k] = width_bank[bank_sel][k];
        bank_sel   = 1'b0;
        failsafe_q = 1'b1;
        ev         = ppmfd_pkg::EV_FAILSAFE;
      end else begin
        warmup_left = warmup_left - 8'd1;
        ev          = ppmfd_pkg::EV_WARMUP;
      end
      run_cnt = '0;
    end else if (!capture_q || run_cnt >= CHANS) begin
      ev = ppmfd_pkg::EV_IGNORED;
    end else if (span < pulse_min_q || span < pulse_max_q || span < gap_min_q) begin
      ev = ppmfd_pkg::EV_IGNORED;
    end else if (span < gap_max_q && polarity_q == beat.edge_level) begin
      // Average the gap with the active bank into the pending bank.
      sum = {1'b0, span} + {1'b0, width_bank[bank_sel][run_cnt[2:0]]};
      width_bank[~bank_sel][run_cnt[2:0]] = sum[16:1];
      note_result(ppmfd_pkg::EV_STORED, run_cnt[2:0], sum[16:1], 1'b1, 1'b1);
      run_cnt = run_cnt + 4'd1;
      emitted = 1'b1;
    end
    if (!emitted)
      note_result(ev, 3'd0, 16'd0, 1'b0, 1'b1);
  endtask

  // Sends one edge beat, idling between bursts, and records what it should cause.
  task automatic send_edge(input logic [15:0] delta, input logic level,
                           input logic typed, input ppmfd_pkg::event_e ev,
                           input logic [3:0] chans);
    ppmfd_pkg::in_t  beat;
    ppmfd_pkg::out_t typed_beat;
    int              k;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
    end
    edge_stamp      = edge_stamp + delta;
    beat.stamp      = edge_stamp;
    beat.edge_level = level;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    burst_left = burst_left - 1;
    sent_cnt   = sent_cnt + 1;
    decode_edge(beat);
    if (typed) begin
      typed_beat                   = '0;
      typed_beat.event_res         = ev;
      typed_beat.detected_channels = chans;
      typed_beat.last              = 1'b1;
      expected_beats.push_back(typed_beat);
    end else begin
      for (k = 0; k < edge_results.size(); k++)
        expected_beats.push_back(edge_results[k]);
    end
  endtask

  // Holds the sender until every expected beat has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ppmfd_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic load_windows(input logic [15:0] smin, input logic [15:0] smax,
                              input logic [15:0] pmin, input logic [15:0] pmax,
                              input logic [15:0] gmin, input logic [15:0] gmax,
                              input logic [7:0] warm);
    write_reg(ppmfd_pkg::CFG_SYNC_MIN, smin);
    write_reg(ppmfd_pkg::CFG_SYNC_MAX, smax);
    write_reg(ppmfd_pkg::CFG_PULSE_MIN, pmin);
    write_reg(ppmfd_pkg::CFG_PULSE_MAX, pmax);
    write_reg(ppmfd_pkg::CFG_GAP_MIN, gmin);
    write_reg(ppmfd_pkg::CFG_GAP_MAX, gmax);
    // Upper byte is don't-care for the warm-up register.
    write_reg(ppmfd_pkg::CFG_WARMUP, {8'($urandom_range(0, 255)), warm});
    cfg_we_i <= 1'b0;
  endtask

  // Random interval in [lo, hi], biased to the bounds; anything when empty or out of range.
  function automatic logic [15:0] pick_span(input int lo, input int hi);
    int r;
    if (lo > hi || lo < 0 || hi > 65535)
      return 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 9);
    if (r == 0)
      return 16'(lo);
    if (r == 1)
      return 16'(hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  // One frame: a sync, then channel gaps, with the odd glitch thrown in.
  task automatic send_frame();
    logic pol;
    int   count;
    int   gap_lo;
    int   i;
    pol = capture_q ? polarity_q : 1'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0)
      pol = ~pol;
    if ($urandom_range(0, 4) != 0)
      count = (learned_q != 0) ? int'(learned_q) : CHANS;
    else
      count = $urandom_range(0, CHANS + 1);
    gap_lo = int'(pulse_min_q);
    if (int'(pulse_max_q) > gap_lo)
      gap_lo = int'(pulse_max_q);
    if (int'(gap_min_q) > gap_lo)
      gap_lo = int'(gap_min_q);
    send_edge(pick_span(int'(sync_min_q) + 1, int'(sync_max_q)), pol, 1'b0,
              ppmfd_pkg::EV_IGNORED, 4'd0);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_edge(16'($urandom_range(0, 1500)), 1'($urandom_range(0, 1)), 1'b0,
                  ppmfd_pkg::EV_IGNORED, 4'd0);
      send_edge(pick_span(gap_lo, int'(gap_max_q) - 1), pol, 1'b0,
                ppmfd_pkg::EV_IGNORED, 4'd0);
    end
  endtask

  // Mostly well-formed frames, some raw noise, and the odd full drain.
  task automatic run_phase(input int items);
    int stop;
    int r;
    stop = sent_cnt + items;
    while (sent_cnt < stop) begin
      r = $urandom_range(0, 99);
      if (r < 78)
        send_frame();
      else if (r < 97)
        send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b0,
                  ppmfd_pkg::EV_IGNORED, 4'd0);
      else
        drain();
    end
  endtask

  // Receiver: the ready pattern switches among open, random and slow styles.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 40 == 0)
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
      default:   out_ready_i <= (cycle_cnt % 5 == 0);
    endcase
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time,
                 out_data_o);
        errors++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("event_res", 16'(want_beat.event_res), 16'(out_data_o.event_res));
        check_field("synced", 16'(want_beat.synced), 16'(out_data_o.synced));
        check_field("detected_channels", 16'(want_beat.detected_channels),
                    16'(out_data_o.detected_channels));
        check_field("channel_index", 16'(want_beat.channel_index),
                    16'(out_data_o.channel_index));
        check_field("channel_width", want_beat.channel_width, out_data_o.channel_width);
        check_field("value_valid", 16'(want_beat.value_valid),
                    16'(out_data_o.value_valid));
        check_field("last", 16'(want_beat.last), 16'(out_data_o.last));
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Main sequence: directed script at reset values, then random phases.
  initial begin
    int i;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < 25; i++)
      send_edge(script[i].delta, script[i].level, script[i].typed, script[i].ev,
                script[i].chans);
    drain();

    // Closed windows, then fully open ones.
    load_windows(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd255);
    run_phase(20);
    drain();
    load_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
    run_phase(20);
    drain();

    // Standard windows with a long warm-up.
    load_windows(ppmfd_pkg::SYNC_MIN_RST, ppmfd_pkg::SYNC_MAX_RST,
                 ppmfd_pkg::PULSE_MIN_RST, ppmfd_pkg::PULSE_MAX_RST,
                 ppmfd_pkg::GAP_MIN_RST, ppmfd_pkg::GAP_MAX_RST, 8'd255);
    run_phase(120);
    drain();

    // Tighter windows, no warm-up: failsafe copy, then accepted frames.
    load_windows(16'd3000, 16'd30000, 16'd300, 16'd700, 16'd800, 16'd2200, 8'd0);
    run_phase(150);
    drain();

    load_windows(ppmfd_pkg::SYNC_MIN_RST, ppmfd_pkg::SYNC_MAX_RST,
                 ppmfd_pkg::PULSE_MIN_RST, ppmfd_pkg::PULSE_MAX_RST,
                 ppmfd_pkg::GAP_MIN_RST, ppmfd_pkg::GAP_MAX_RST, 8'd5);
    run_phase(140);

    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_beats.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
